[rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication with the consequent checked in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[rtl/lsfp_pkg.sv]
package lsfp_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegPixelCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFadeWidth = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPatternMode = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoolLevel = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAmberLevel = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWarmLevel = 3'd5;

  typedef enum logic [2:0] {
    ModeBasic = 3'd0, ModeRows = 3'd1, ModeEnds = 3'd2, ModeCenter = 3'd3,
    ModeLeft = 3'd4, ModeRight = 3'd5, ModeSparkle = 3'd6, ModeSpare = 3'd7
  } mode_e;

  // floor(x/255) for x < 65280: q = (x + 1 + (x >> 8)) >> 8
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

  function automatic logic [7:0] mix_index(input logic [9:0] idx);
    logic [15:0] x;
    logic [31:0] m;
    x = {6'd0, idx};
    x = x ^ (x >> 7);
    x = x ^ (x << 9);
    m = x * 32'h9E37;
    return m[7:0] ^ m[15:8];
  endfunction
endpackage

[rtl/led_strip_fade_pattern_top.sv]
// Data path: 7 register stages between input request accept and result output
// (the last one is the output register).
// Throughput: one request per cycle; a stall on the result side freezes all stages together.
// The divide is a restoring unit, 4 quotient bits in each of stages 4 and 5.
// Reset (rst_ni low, asynchronous) clears valid bits and sets registers to
// pixel_count=1, fade_width=8, pattern_mode=basic, all levels 255.
module led_strip_fade_pattern_top #(
  parameter int unsigned MAX_PIXELS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] power, [17:8] pixel_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // cool, amber, warm, index_out (10b)
  input  logic        cfg_we_i,
  input  logic [lsfp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [10:0] cfg_data_i
);
  import lsfp_pkg::*;

  localparam int unsigned NW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned NSTG = 7;
  // numerator magnitude bound: 255*(N+2W)+... fits 32 bits signed comfortably
  localparam int unsigned XW = 34;

  logic [10:0] pixel_count_q;
  logic [7:0]  fade_width_q, cool_q, amber_q, warm_q;
  logic [2:0]  mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= 11'd1;
      fade_width_q <= 8'd8;
      mode_q <= ModeBasic;
      cool_q <= 8'hFF;
      amber_q <= 8'hFF;
      warm_q <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPixelCount:  pixel_count_q <= cfg_data_i;
        RegFadeWidth:   fade_width_q <= cfg_data_i[7:0];
        RegPatternMode: mode_q <= cfg_data_i[2:0];
        RegCoolLevel:   cool_q <= cfg_data_i[7:0];
        RegAmberLevel:  amber_q <= cfg_data_i[7:0];
        RegWarmLevel:   warm_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Global enable: stages advance unless the output holds a result not taken.
  logic adv;
  logic [NSTG-1:0] vld_q;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
  end
  assign m_axis_tvalid = vld_q[NSTG-1];

  // ---------------- stage 1: operand setup ----------------
  logic [7:0] p_in;
  logic [9:0] i_in;
  assign p_in = s_axis_tdata[7:0];
  assign i_in = s_axis_tdata[17:8];

  logic [NW-1:0] n_c;
  assign n_c = (32'(pixel_count_q) > MAX_PIXELS) ? NW'(MAX_PIXELS) : NW'(pixel_count_q);

  logic signed [XW-1:0] sn, sw, si, ap, mterm, pmul;
  logic signed [XW-1:0] s1_mul_q, s1_sub_q;
  logic [8:0] s1_den_q;
  logic [7:0] s1_p_q, s1_h_q;
  logic [9:0] s1_i_q;
  logic [2:0] s1_mode_q;
  always_comb begin
    sn = XW'(n_c);
    sw = XW'(fade_width_q);
    si = XW'(i_in);
    pmul = '0;
    mterm = '0;
    ap = '0;
    unique case (mode_q)
      ModeEnds: begin
        pmul = sn + 2 * sw;
        mterm = (si < sn - 1 - si) ? 510 * si : 510 * (sn - 1 - si);
      end
      ModeCenter: begin
        pmul = sn - 1 + 2 * sw;
        ap = 2 * si - (sn - 1);
        mterm = 255 * ((ap < 0) ? -ap : ap);
      end
      ModeLeft: begin
        pmul = sn + sw;
        mterm = 255 * si;
      end
      ModeRight: begin
        pmul = sn + sw;
        mterm = 255 * (sn - si);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mul_q <= pmul;
      s1_sub_q <= mterm;
      s1_den_q <= (mode_q == ModeEnds || mode_q == ModeCenter) ?
                  {fade_width_q, 1'b0} : {1'b0, fade_width_q};
      s1_p_q <= p_in;
      s1_i_q <= i_in;
      s1_mode_q <= mode_q;
      s1_h_q <= mix_index(i_in);
    end
  end

  // ---------------- stage 2: multiply ----------------
  logic signed [XW-1:0] num2;
  logic [15:0] th_prod;
  logic signed [XW-1:0] s2_num_q;
  logic [15:0] s2_th_q;
  logic [8:0] s2_den_q;
  logic [7:0] s2_p_q;
  logic [9:0] s2_i_q;
  logic [2:0] s2_mode_q;
  assign num2 = XW'($signed({1'b0, s1_p_q})) * s1_mul_q - s1_sub_q;
  assign th_prod = 16'(s1_h_q) * 16'(8'd255 - fade_width_q);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_num_q <= num2;
      s2_th_q <= th_prod;
      s2_den_q <= s1_den_q;
      s2_p_q <= s1_p_q;
      s2_i_q <= s1_i_q;
      s2_mode_q <= s1_mode_q;
    end
  end

  // ---------------- stage 3: normalize to divide request ----------------
  // Produces saturated numerator (<= 255*den+den) and a forced result flag.
  logic [17:0] s3_num_q;
  logic [8:0] s3_den_q;
  logic s3_force_q;
  logic [7:0] s3_fval_q;
  logic [9:0] s3_i_q;
  logic [17:0] cap;
  logic [17:0] nm;
  logic fz;
  logic [7:0] fv;
  logic signed [9:0] dsp;
  logic [7:0] t3;
  always_comb begin
    cap = 18'(s2_den_q) * 18'd256;
    nm = '0;
    fz = 1'b1;
    fv = 8'd0;
    t3 = div255(s2_th_q);
    dsp = $signed({2'b0, s2_p_q}) - $signed({2'b0, t3});
    unique case (s2_mode_q)
      ModeEnds, ModeCenter, ModeLeft, ModeRight: begin
        if (s2_num_q <= 0) fv = 8'd0;
        else if (s2_den_q == 9'd0) fv = 8'hFF;
        else if (s2_num_q >= $signed(XW'(cap))) fv = 8'hFF;
        else begin
          fz = 1'b0;
          nm = s2_num_q[17:0];
        end
      end
      ModeSparkle: begin
        if (dsp <= 0) fv = 8'd0;
        else if (dsp >= $signed({2'b0, s2_den_q[7:0]})) fv = 8'hFF;
        else begin
          fz = 1'b0;
          nm = 18'(dsp[7:0]) * 18'd255;
        end
      end
      ModeRows: begin
        if (!s2_i_q[0]) fv = (s2_p_q >= 8'd128) ? 8'hFF : {s2_p_q[6:0], 1'b0};
        else fv = (s2_p_q > 8'd128) ? {s2_p_q[6:0], 1'b0} : 8'd0;
      end
      default: fv = s2_p_q;
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_num_q <= nm;
      s3_den_q <= s2_den_q;
      s3_force_q <= fz;
      s3_fval_q <= fv;
      s3_i_q <= s2_i_q;
    end
  end

  // ---------------- stage 4: restoring divide, quotient bits 7..4 ----------------
  logic [17:0] rem_hi;
  logic [3:0] q_hi;
  logic [17:0] trial_hi;
  always_comb begin
    rem_hi = s3_num_q;
    q_hi = '0;
    trial_hi = '0;
    for (int b = 3; b >= 0; b--) begin
      trial_hi = 18'(s3_den_q) << (b + 4);
      if (rem_hi >= trial_hi) begin
        rem_hi = rem_hi - trial_hi;
        q_hi[b] = 1'b1;
      end
    end
  end
  logic [17:0] s4_rem_q;
  logic [3:0] s4_qh_q;
  logic [8:0] s4_den_q;
  logic s4_force_q;
  logic [7:0] s4_fval_q;
  logic [9:0] s4_i_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_rem_q <= rem_hi;
      s4_qh_q <= q_hi;
      s4_den_q <= s3_den_q;
      s4_force_q <= s3_force_q;
      s4_fval_q <= s3_fval_q;
      s4_i_q <= s3_i_q;
    end
  end

  // ---------------- stage 5: restoring divide, quotient bits 3..0 ----------------
  logic [17:0] rem_lo;
  logic [3:0] q_lo;
  logic [17:0] trial_lo;
  always_comb begin
    rem_lo = s4_rem_q;
    q_lo = '0;
    trial_lo = '0;
    for (int b = 3; b >= 0; b--) begin
      trial_lo = 18'(s4_den_q) << b;
      if (rem_lo >= trial_lo) begin
        rem_lo = rem_lo - trial_lo;
        q_lo[b] = 1'b1;
      end
    end
  end
  logic [7:0] s5_v_q;
  logic [9:0] s5_i_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_v_q <= s4_force_q ? s4_fval_q : {s4_qh_q, q_lo};
      s5_i_q <= s4_i_q;
    end
  end

  // ---------------- stage 6: channel scale multiply ----------------
  logic [15:0] s6_c_q, s6_a_q, s6_w_q;
  logic [9:0] s6_i_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_c_q <= 16'(cool_q) * 16'(s5_v_q);
      s6_a_q <= 16'(amber_q) * 16'(s5_v_q);
      s6_w_q <= 16'(warm_q) * 16'(s5_v_q);
      s6_i_q <= s5_i_q;
    end
  end

  // ---------------- stage 7: divide by 255, output register ----------------
  logic [39:0] s7_q;
  always_ff @(posedge clk_i) begin
    if (adv) s7_q <= {6'd0, s6_i_q, div255(s6_w_q), div255(s6_a_q), div255(s6_c_q)};
  end
  assign m_axis_tdata = s7_q;

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_stall_holds_valid, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_IMPL(a_ready_follows_out, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)
  `ASSERT_NEXT(a_stall_holds_pipe, clk_i, rst_ni, !adv, $stable(vld_q))
endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lsfp_pkg::*;

  // one pixel request: power and pixel index
  typedef struct packed {
    logic [9:0] pixel;
    logic [7:0] power;
  } pix_req_t;

  // one shaded pixel: three channel intensities and the echoed index
  typedef struct packed {
    logic [9:0] pixel;
    logic [7:0] warm;
    logic [7:0] amber;
    logic [7:0] cool;
  } pix_rgb_t;

  // directed row: config write (if any), request, and optional typed-in result
  typedef struct {
    logic          do_cfg;
    logic [2:0]    cfg_idx;
    logic [10:0]   cfg_val;
    pix_req_t      req;
    logic          has_exp;
    pix_rgb_t      exp_px;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [7:0] power, [17:8] pixel_index
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // [7:0] cool, [15:8] amber, [23:16] warm, [33:24] index
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [10:0] cfg_data_i = '0;

  led_strip_fade_pattern_top i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the register file
  logic [10:0] sh_count;
  logic [7:0]  sh_width;
  logic [2:0]  sh_mode;
  logic [7:0]  sh_cool, sh_amber, sh_warm;

  pix_rgb_t pending_px[$];
  int       n_err = 0;
  int       n_seen = 0;
  int       n_sent = 0;
  longint   cyc = 0;
  bit       calm = 1'b0;   // no idling in the final stretch

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > 400000) begin
      $display("timeout after %0d cycles", cyc);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_err(input string what, input int got, input int want);
    $display("mismatch on %s at result %0d: got %0d, want %0d", what, n_seen, got, want);
    n_err++;
  endtask

  function automatic logic [7:0] sat_quot(input longint num, input longint den);
    longint q;
    if (num <= 0) return 8'd0;
    if (den <= 0) return 8'd255;
    q = num / den;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic logic [7:0] pixel_hash(input logic [9:0] idx);
    logic [15:0] x;
    logic [31:0] m;
    x = {6'd0, idx};
    x = x ^ (x >> 7);
    x = x ^ (x << 9);
    m = x * 32'h9E37;
    return m[7:0] ^ m[15:8];
  endfunction

  // pattern intensity before channel scaling
  function automatic logic [7:0] fade_level(input logic [7:0] pw, input logic [9:0] idx);
    longint p, i, n, w, m, a, d;
    int unsigned t;
    p = pw; i = idx; w = sh_width;
    n = (sh_count > 1024) ? 1024 : sh_count;
    case (mode_e'(sh_mode))
      ModeRows: begin
        if (!idx[0]) return (pw >= 128) ? 8'd255 : {pw[6:0], 1'b0};
        return (pw > 128) ? {pw[6:0], 1'b0} : 8'd0;
      end
      ModeEnds: begin
        m = n - 1 - i;
        if (i < m) m = i;
        return sat_quot(p * (n + 2 * w) - 510 * m, 2 * w);
      end
      ModeCenter: begin
        a = 2 * i - (n - 1);
        if (a < 0) a = -a;
        return sat_quot(p * (n - 1 + 2 * w) - 255 * a, 2 * w);
      end
      ModeLeft:  return sat_quot(p * (n + w) - 255 * i, w);
      ModeRight: return sat_quot(p * (n + w) - 255 * (n - i), w);
      ModeSparkle: begin
        t = pixel_hash(idx) * (255 - sh_width) / 255;
        d = p - t;
        if (d <= 0) return 8'd0;
        if (d >= w) return 8'd255;
        return 8'((255 * d) / w);
      end
      default: return pw;
    endcase
  endfunction

  function automatic pix_rgb_t shade_pixel(input pix_req_t r);
    pix_rgb_t o;
    int unsigned v;
    v = 32'(fade_level(r.power, r.pixel));
    o.cool  = 8'(sh_cool * v / 255);
    o.amber = 8'(sh_amber * v / 255);
    o.warm  = 8'(sh_warm * v / 255);
    o.pixel = r.pixel;
    return o;
  endfunction

  // output side: random stall bursts, compare each accepted result
  initial begin
    int burst;
    pix_rgb_t got, want;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[33:0];
        if (m_axis_tdata[39:34] != 0) report_err("pad bits", m_axis_tdata[39:34], 0);
        if (pending_px.size() == 0) begin
          report_err("unexpected result", got.pixel, -1);
        end else begin
          want = pending_px.pop_front();
          if (got.cool != want.cool)   report_err("cool", got.cool, want.cool);
          if (got.amber != want.amber) report_err("amber", got.amber, want.amber);
          if (got.warm != want.warm)   report_err("warm", got.warm, want.warm);
          if (got.pixel != want.pixel) report_err("index", got.pixel, want.pixel);
        end
        n_seen++;
      end
      if (burst > 0) begin
        burst--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // register write while idle; shadow follows
  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegPixelCount:  sh_count = val;
      RegFadeWidth:   sh_width = val[7:0];
      RegPatternMode: sh_mode  = val[2:0];
      RegCoolLevel:   sh_cool  = val[7:0];
      RegAmberLevel:  sh_amber = val[7:0];
      RegWarmLevel:   sh_warm  = val[7:0];
      default: ;
    endcase
  endtask

  // wait until every expected result has been accepted
  task automatic drain;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // drive one request; idle bursts only between requests
  task automatic send_pixel(input pix_req_t r);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, r};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_px.push_back(shade_pixel(r));
    n_sent++;
  endtask

  function automatic pix_req_t rand_pixel(input logic [10:0] cnt);
    pix_req_t r;
    r.power = 8'($urandom_range(0, 255));
    // mostly on the strip, sometimes past its end
    if ($urandom_range(0, 3) != 0 && cnt != 0)
      r.pixel = 10'($urandom_range(0, (cnt > 1024 ? 1024 : cnt) - 1));
    else
      r.pixel = 10'($urandom_range(0, 1023));
    return r;
  endfunction

  // directed table: reset result, extremes, every mode, the rows 128 case,
  // zero width hard edges, spare mode, off-strip pixel, zero pixel count
  dir_row_t dir_tab[] = '{
    '{0, RegPixelCount, 0,    '{10'd0,    8'd200}, 1, '{10'd0, 8'd200, 8'd200, 8'd200}},
    '{0, RegPixelCount, 0,    '{10'd1023, 8'd255}, 1, '{10'd1023, 8'd255, 8'd255, 8'd255}},
    '{0, RegPixelCount, 0,    '{10'd5,    8'd0},   1, '{10'd5, 8'd0, 8'd0, 8'd0}},
    '{1, RegPatternMode, ModeRows, '{10'd2, 8'd128}, 1, '{10'd2, 8'd255, 8'd255, 8'd255}},
    '{0, RegPixelCount, 0,    '{10'd3,    8'd128}, 1, '{10'd3, 8'd0, 8'd0, 8'd0}},
    '{0, RegPixelCount, 0,    '{10'd7,    8'd255}, 0, '{default: 0}},
    '{1, RegPixelCount, 11'd1024, '{10'd0, 8'd100}, 0, '{default: 0}},
    '{1, RegPatternMode, ModeEnds, '{10'd512, 8'd37}, 0, '{default: 0}},
    '{1, RegPatternMode, ModeCenter, '{10'd0, 8'd90}, 0, '{default: 0}},
    '{1, RegPatternMode, ModeLeft, '{10'd1023, 8'd250}, 0, '{default: 0}},
    '{1, RegPatternMode, ModeRight, '{10'd1, 8'd12}, 0, '{default: 0}},
    '{1, RegPatternMode, ModeSparkle, '{10'd77, 8'd200}, 0, '{default: 0}},
    '{1, RegFadeWidth, 11'd0, '{10'd300, 8'd1}, 0, '{default: 0}},
    '{1, RegPatternMode, ModeLeft, '{10'd300, 8'd1}, 0, '{default: 0}},
    '{1, RegPatternMode, ModeEnds, '{10'd0, 8'd0}, 0, '{default: 0}},
    '{1, RegFadeWidth, 11'd255, '{10'd600, 8'd255}, 0, '{default: 0}},
    '{1, RegPatternMode, ModeSparkle, '{10'd1000, 8'd255}, 0, '{default: 0}},
    '{1, RegPixelCount, 11'd2047, '{10'd1023, 8'd128}, 0, '{default: 0}},
    '{1, RegPatternMode, ModeSpare, '{10'd44, 8'd99}, 0, '{default: 0}},
    '{1, RegPixelCount, 11'd0, '{10'd0, 8'd255}, 0, '{default: 0}},
    '{1, RegPatternMode, ModeCenter, '{10'd1023, 8'd255}, 0, '{default: 0}},
    '{1, RegCoolLevel, 11'd0, '{10'd8, 8'd255}, 0, '{default: 0}},
    '{1, RegAmberLevel, 11'd1, '{10'd9, 8'd254}, 0, '{default: 0}},
    '{1, RegWarmLevel, 11'd128, '{10'd10, 8'd170}, 0, '{default: 0}}
  };

  initial begin
    pix_req_t r;
    int n_dir;
    sh_count = 11'd1; sh_width = 8'd8; sh_mode = ModeBasic;
    sh_cool = 8'd255; sh_amber = 8'd255; sh_warm = 8'd255;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].do_cfg) begin
        // stop offering the last request before the pipeline drains
        s_axis_tvalid <= 1'b0;
        drain();
        write_reg(dir_tab[k].cfg_idx, dir_tab[k].cfg_val);
      end
      send_pixel(dir_tab[k].req);
      // typed-in value overrides the predictor for the plain rows
      if (dir_tab[k].has_exp) pending_px[$] = dir_tab[k].exp_px;
    end
    s_axis_tvalid <= 1'b0;
    n_dir = n_sent;

    // random phases: new register setting, then a run of pixels
    for (int ph = 0; ph < 20; ph++) begin
      drain();
      if (ph == 16) calm = 1'b1;
      write_reg(RegPixelCount, 11'((ph % 5 == 0) ? 1024 : (ph % 7 == 3) ? 0 :
                $urandom_range(1, 64)));
      write_reg(RegFadeWidth, 11'((ph % 6 == 1) ? 0 : (ph % 6 == 2) ? 255 :
                $urandom_range(1, 40)));
      write_reg(RegPatternMode, 11'(ph % 8));
      write_reg(RegCoolLevel, 11'((ph % 4 == 0) ? 255 : $urandom_range(0, 255)));
      write_reg(RegAmberLevel, 11'((ph % 4 == 1) ? 0 : $urandom_range(0, 255)));
      write_reg(RegWarmLevel, 11'($urandom_range(0, 255)));
      for (int k = 0; k < 20; k++) begin
        r = rand_pixel(sh_count);
        send_pixel(r);
      end
      s_axis_tvalid <= 1'b0;
    end

    drain();
    $display("covered %0d directed and %0d random pixels over all modes, %0d results",
             n_dir, n_sent - n_dir, n_seen);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", n_err);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
